// ===== src/vector4_reflect_refract_defines.svh =====
// assertion macros for the reflect/refract block checker
// clk and rst must be visible where these are used
`ifndef VECTOR4_REFLECT_REFRACT_DEFINES_SVH
`define VECTOR4_REFLECT_REFRACT_DEFINES_SVH

// same-cycle implication
`define VRR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vrr check failed");

// next-cycle implication
`define VRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vrr check failed");

`endif

// ===== src/vrr_pkg.sv =====
// types, constants and fixed-point helpers for the reflect/refract pipeline
// no dependencies
package vrr_pkg;

  localparam int FRAC_BITS = 12;
  localparam int SQ_BITS   = 14;  // root width
  localparam int RAD_BITS  = 2 * SQ_BITS;
  localparam int REM_BITS  = SQ_BITS + 4;
  localparam int SQ_STAGES = 7;   // two root bits per stage

  typedef logic signed [15:0] q_t;
  typedef logic signed [47:0] w_t;

  // payload that rides along most of the pipeline
  typedef struct packed {
    logic          mode;
    logic          tir;
    logic [14:0]   eta;
    q_t            sr;
    q_t            etat;
    q_t [3:0]      iv;
    q_t [3:0]      nv;
    q_t [3:0]      ei;
  } ctx_t;

  typedef struct packed {
    logic [RAD_BITS-1:0] rad;
    logic [REM_BITS-1:0] rem;
    logic [SQ_BITS-1:0]  root;
  } sq_t;

  localparam w_t ONE_Q  = 48'sd4096;
  localparam w_t HALF_Q = 48'sd2048;

  function automatic q_t sat16(input w_t v);
    q_t r;
    if (v > 48'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -48'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // round to nearest, ties up, then saturate
  function automatic q_t rnd_sat(input w_t p);
    w_t q;
    q = (p + HALF_Q) >>> FRAC_BITS;
    return sat16(q);
  endfunction

  // one restoring square-root digit
  function automatic sq_t sqrt_step(input sq_t s);
    sq_t                 o;
    logic [REM_BITS-1:0] remx;
    logic [REM_BITS-1:0] trial;
    remx  = {s.rem[REM_BITS-3:0], s.rad[RAD_BITS-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    o.rad = {s.rad[RAD_BITS-3:0], 2'b00};
    if (remx >= trial) begin
      o.rem  = remx - trial;
      o.root = {s.root[SQ_BITS-2:0], 1'b1};
    end else begin
      o.rem  = remx;
      o.root = {s.root[SQ_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ===== src/vector4_reflect_refract.sv =====
// channel  dir  tdata (low bit up)                              tuser
// s_axis   in   inc_x,inc_y,inc_z,inc_w,nrm_x..nrm_w,eta,pad  mode
// m_axis   out  out_x,out_y,out_z,out_w                       total_internal
//
// 16-stage pipeline, one transfer accepted per cycle while m_axis is not stalled.
// the square root takes seven of those stages, two root bits each.
// a stall on m_axis freezes every stage; nothing is dropped or repeated.
// rst clears the valid bits only.
module vector4_reflect_refract
  import vrr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,  // inc_x,inc_y,inc_z,inc_w,nrm_x,nrm_y,nrm_z,nrm_w,eta,pad
  input  logic [0:0]   s_axis_tuser,  // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // out_x,out_y,out_z,out_w
  output logic [0:0]   m_axis_tuser   // total_internal
);

  localparam int NST = 9 + SQ_STAGES;

  logic            en;
  logic [NST-1:0]  vld;

  // stage 1
  ctx_t            c1, c1_next;
  logic signed [31:0] prod1 [4];
  logic [29:0]     ee1;
  // stage 2
  ctx_t            c2;
  q_t              t2, e2_2;
  // stage 3
  ctx_t            c3, c3_next;
  q_t              e2_3;
  logic signed [31:0] tt3, et3;
  logic signed [31:0] ei3 [4];
  // stage 4
  ctx_t            c4, c4_next;
  q_t              e2_4, u4;
  // stage 5
  ctx_t            c5;
  logic signed [31:0] eu5;
  // stage 6
  ctx_t            c6, c6_next;
  sq_t             s6, s6_next;
  q_t              r6;
  // root stages
  ctx_t            qc [SQ_STAGES];
  sq_t             qs [SQ_STAGES];
  sq_t             qn [SQ_STAGES];
  // tail
  ctx_t            cs, cp;
  q_t              ss;
  logic signed [31:0] pp [4];
  q_t              ofin [4];

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_axis_tvalid};
    end
  end

  assign r6 = sat16(ONE_Q - 48'(rnd_sat(48'(eu5))));

  // next values of the payload registers that change some fields
  always_comb begin
    c1_next      = '0;
    c1_next.mode = s_axis_tuser[0];
    c1_next.eta  = s_axis_tdata[142:128];
    for (int k = 0; k < 4; k++) begin
      c1_next.iv[k] = s_axis_tdata[16*k +: 16];
      c1_next.nv[k] = s_axis_tdata[64 + 16*k +: 16];
    end

    c3_next    = c2;
    c3_next.sr = sat16(48'(t2) + 48'(t2));

    c4_next      = c3;
    c4_next.etat = rnd_sat(48'(et3));
    for (int k = 0; k < 4; k++) begin
      c4_next.ei[k] = rnd_sat(48'(ei3[k]));
    end

    // radicand sign gives total internal reflection
    c6_next     = c5;
    c6_next.tir = r6[15];
    s6_next     = '0;
    s6_next.rad = {1'b0, r6[14:0], {FRAC_BITS{1'b0}}};
  end

  always_comb begin
    qn[0] = sqrt_step(sqrt_step(s6));
    for (int j = 1; j < SQ_STAGES; j++) begin
      qn[j] = sqrt_step(sqrt_step(qs[j-1]));
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (cp.mode && cp.tir) begin
        ofin[k] = '0;
      end else begin
        ofin[k] = sat16(48'(cp.mode ? $signed(cp.ei[k]) : $signed(cp.iv[k]))
                        - 48'(rnd_sat(48'(pp[k]))));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: unpack, lane products
      c1 <= c1_next;
      for (int k = 0; k < 4; k++) begin
        prod1[k] <= $signed(s_axis_tdata[16*k +: 16])
                    * $signed(s_axis_tdata[64 + 16*k +: 16]);
      end
      ee1 <= s_axis_tdata[142:128] * s_axis_tdata[142:128];

      // stage 2: dot product, eta squared
      c2   <= c1;
      t2   <= rnd_sat(48'(prod1[0]) + 48'(prod1[1]) + 48'(prod1[2]) + 48'(prod1[3]));
      e2_2 <= rnd_sat(48'($signed({1'b0, ee1})));

      // stage 3
      c3    <= c3_next;
      e2_3  <= e2_2;
      tt3   <= t2 * t2;
      et3   <= $signed({1'b0, c2.eta}) * t2;
      for (int k = 0; k < 4; k++) begin
        ei3[k] <= $signed({1'b0, c2.eta}) * $signed(c2.iv[k]);
      end

      // stage 4
      c4   <= c4_next;
      e2_4 <= e2_3;
      u4   <= sat16(ONE_Q - 48'(rnd_sat(48'(tt3))));

      // stage 5
      c5  <= c4;
      eu5 <= e2_4 * u4;

      // stage 6: radicand
      c6 <= c6_next;
      s6 <= s6_next;

      // root digits
      qc[0] <= c6;
      for (int j = 1; j < SQ_STAGES; j++) begin
        qc[j] <= qc[j-1];
      end
      for (int j = 0; j < SQ_STAGES; j++) begin
        qs[j] <= qn[j];
      end

      // final scale factor
      cs <= qc[SQ_STAGES-1];
      ss <= qc[SQ_STAGES-1].mode
            ? sat16(48'(qc[SQ_STAGES-1].etat) + 48'(qs[SQ_STAGES-1].root))
            : qc[SQ_STAGES-1].sr;

      // s * normal
      cp <= cs;
      for (int k = 0; k < 4; k++) begin
        pp[k] <= ss * $signed(cs.nv[k]);
      end

      // output register
      m_axis_tdata    <= {ofin[3], ofin[2], ofin[1], ofin[0]};
      m_axis_tuser[0] <= cp.mode & cp.tir;
    end
  end

endmodule

// ===== src/vrr_check.sv =====
// port-level checks for the reflect/refract pipeline, bound to the top level
// uses the assertion macros from vector4_reflect_refract_defines.svh
`include "vector4_reflect_refract_defines.svh"

module vrr_check (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [143:0] s_axis_tdata,   // inc_x..inc_w,nrm_x..nrm_w,eta,pad
  input logic [0:0]   s_axis_tuser,   // mode
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [63:0]  m_axis_tdata,   // out_x,out_y,out_z,out_w
  input logic [0:0]   m_axis_tuser    // total_internal
);

  // a held result keeps its payload
  `VRR_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // total internal reflection forces the zero vector
  `VRR_ASSERT_NOW(a_tir_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 64'd0)

  // the input side stalls only when a result waits
  `VRR_ASSERT_NOW(a_ready, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready))

endmodule

bind vector4_reflect_refract vrr_check u_vrr_check (.*);

// ===== test/testbench.sv =====
// self-checking testbench for the vector4_reflect_refract pipeline
// depends on vrr_pkg (q_t) and the vector4_reflect_refract top level
module testbench;
  import vrr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 16;
  localparam int WDOG_MAX  = 5000;
  localparam int N_RANDOM  = 400;

  localparam logic MODE_REFLECT = 1'b0;
  localparam logic MODE_REFRACT = 1'b1;

  typedef struct packed {
    logic        mode;
    q_t [3:0]    inc;
    q_t [3:0]    nrm;
    logic [14:0] eta;
  } ray_t;

  typedef struct packed {
    q_t [3:0] vec;
    logic     tir;
  } bend_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  ray_t  ray_q[$];
  bend_t bend_q[$];
  int    n_err = 0;
  int    n_sent = 0;
  int    n_recv = 0;
  int    n_tir = 0;
  int    n_refract = 0;
  int    wdog = 0;
  int    hold_off = 0;
  bit    pressed = 1'b0;
  bit    calm = 1'b0;
  bit    stim_done = 1'b0;

  vector4_reflect_refract u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint clamp16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // round half up back to q.12; >>> is floor on signed
  function automatic longint qround(input longint p);
    return (p + 2048) >>> 12;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return clamp16(qround(a * b));
  endfunction

  function automatic longint root_floor(input longint n);
    longint lo, hi, mid;
    lo = 0;
    hi = 1 << 24;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= n) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic bend_t bend_ray(input ray_t r);
    bend_t  b;
    longint acc, t, s, u, e2, rad, e;
    acc = 0;
    e = longint'(r.eta);
    for (int k = 0; k < 4; k++) acc += longint'(r.inc[k]) * longint'(r.nrm[k]);
    t = clamp16(qround(acc));
    b.tir = 1'b0;
    if (r.mode == MODE_REFLECT) begin
      s = clamp16(2 * t);
      for (int k = 0; k < 4; k++)
        b.vec[k] = q_t'(clamp16(longint'(r.inc[k]) - qmul(s, longint'(r.nrm[k]))));
    end else begin
      u = clamp16(4096 - qmul(t, t));
      e2 = qmul(e, e);
      rad = clamp16(4096 - qmul(e2, u));
      if (rad < 0) begin
        b.tir = 1'b1;
        b.vec = '0;
      end else begin
        s = clamp16(qmul(e, t) + root_floor(rad << 12));
        for (int k = 0; k < 4; k++)
          b.vec[k] = q_t'(clamp16(qmul(e, longint'(r.inc[k])) - qmul(s, longint'(r.nrm[k]))));
      end
    end
    return b;
  endfunction

  function automatic ray_t rand_ray(input bit unit_ish);
    ray_t r;
    r.mode = 1'($urandom_range(0, 1));
    for (int k = 0; k < 4; k++) begin
      if (unit_ish) begin
        r.inc[k] = q_t'($urandom_range(0, 4096) - 2048);
        r.nrm[k] = q_t'($urandom_range(0, 4096) - 2048);
      end else begin
        r.inc[k] = q_t'($urandom);
        r.nrm[k] = q_t'($urandom);
      end
    end
    r.eta = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 16384));
    return r;
  endfunction

  task automatic push_ray(input logic m, input int iv, input int nv, input int e);
    ray_t r;
    r.mode = m;
    for (int k = 0; k < 4; k++) begin
      r.inc[k] = q_t'(iv);
      r.nrm[k] = q_t'(nv);
    end
    r.eta = 15'(e);
    ray_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    n_err++;
  endtask

  // driver: one transfer per accepted cycle, random idle outside the calm window
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (ray_q.size() > 0 && (calm || $urandom_range(0, 99) >= 24)) begin
        ray_t r;
        r = ray_q.pop_front();
        bend_q.push_back(bend_ray(r));
        s_axis_tdata  <= {1'b0, r.eta, r.nrm, r.inc};
        s_axis_tuser  <= r.mode;
        s_axis_tvalid <= 1'b1;
        n_sent++;
        if (r.mode == MODE_REFRACT) n_refract++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver backpressure, with one long hold-off so the pipe fills up
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else if (!pressed && n_sent >= 60) begin
      pressed <= 1'b1;
      hold_off <= 80;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || $urandom_range(0, 99) >= 24;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      bend_t want;
      if (bend_q.size() == 0) begin
        $display("unexpected result transfer");
        n_err++;
      end else begin
        want = bend_q.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (q_t'(m_axis_tdata[16*k +: 16]) != want.vec[k])
            report_mismatch($sformatf("out[%0d]", k),
                            q_t'(m_axis_tdata[16*k +: 16]), want.vec[k]);
        end
        if (m_axis_tuser[0] != want.tir)
          report_mismatch("total_internal", m_axis_tuser[0], want.tir);
        if (want.tir) n_tir++;
      end
      n_recv++;
    end
  end

  // watchdog on cycles without any transfer, cleared once the stimulus is done
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || stim_done)
      wdog <= 0;
    else
      wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    // directed: extremes, both modes, total internal reflection, wide eta
    push_ray(MODE_REFLECT, 0, 0, 0);
    push_ray(MODE_REFLECT, 32767, 32767, 0);
    push_ray(MODE_REFLECT, -32768, -32768, 0);
    push_ray(MODE_REFLECT, 32767, -32768, 32767);
    push_ray(MODE_REFLECT, 4096, 2048, 4096);
    push_ray(MODE_REFRACT, 0, 0, 0);
    push_ray(MODE_REFRACT, 2048, 2048, 4096);
    push_ray(MODE_REFRACT, 2048, -2048, 6144);
    push_ray(MODE_REFRACT, 1024, 0, 16384);
    push_ray(MODE_REFRACT, 0, 2048, 16384);
    push_ray(MODE_REFRACT, 32767, 32767, 32767);
    push_ray(MODE_REFRACT, -32768, -32768, 32767);
    push_ray(MODE_REFRACT, -32768, 32767, 16384);
    push_ray(MODE_REFRACT, 4096, 4096, 3000);
    push_ray(MODE_REFRACT, 100, -3000, 20000);
    push_ray(MODE_REFRACT, -1, 1, 1);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 150) begin
        wait (ray_q.size() == 0);
        calm = 1'b1;
      end
      if (i == 250) begin
        wait (ray_q.size() == 0);
        calm = 1'b0;
      end
      ray_q.push_back(rand_ray($urandom_range(0, 3) != 0));
    end
    wait (ray_q.size() == 0 && !s_axis_tvalid);
    stim_done = 1'b1;
    fork
      wait (bend_q.size() == 0);
      begin
        repeat (WDOG_MAX) @(posedge clk);
      end
    join_any
    disable fork;
    repeat (LATENCY + 4) @(posedge clk);
    $display("sent %0d rays (%0d refract), got %0d results, %0d total internal",
             n_sent, n_refract, n_recv, n_tir);
    if (bend_q.size() == 0 && n_err == 0) begin
      $display("PASS");
    end else begin
      if (bend_q.size() != 0) $display("%0d results never arrived", bend_q.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== vector4_reflect_refract.f =====
+incdir+src
src/vrr_pkg.sv
src/vector4_reflect_refract.sv
src/vrr_check.sv
test/testbench.sv
